// ----- hdl/jfml_pkg.sv -----
package jfml_pkg;

	typedef logic [7:0] char_t;

	localparam char_t CH_STX   = 8'h02;
	localparam char_t CH_ETX   = 8'h03;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_LF    = 8'h0A;
	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_STAR  = 8'h2A;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_ONE   = 8'h31;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_F     = 8'h46;
	localparam char_t CH_L     = 8'h4C;

	localparam int TOTAL_W = 14;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 14'd8192;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_F_TWICE,
		ERR_F_VALUE,
		ERR_FUSE_NUM,
		ERR_NUM_RANGE,
		ERR_BIT_CHAR,
		ERR_PAST_END
	} err_t;

	typedef enum logic [1:0] {
		PH_WAIT_STX,
		PH_PARSE,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [3:0] {
		PM_WAIT_STX,
		PM_HEADER,
		PM_FIELD,
		PM_FVAL,
		PM_LNUM,
		PM_SKIP,
		PM_LBITS,
		PM_DONE,
		PM_ERROR
	} pmode_t;

	typedef enum logic [2:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_EXEC,
		SQ_FILL,
		SQ_RESP
	} seq_t;

	typedef struct packed {
		phase_t      phase;
		err_t        error_code;
		logic        fuse_bit;
		logic [15:0] fuse_checksum;
	} res_t;

	function automatic logic is_space(char_t c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

// ----- hdl/jedec_fuse_map_loader_unit.sv -----
// channel  direction  handshake                 payload
// in       input      in_valid / in_ready       cmd, char_in, read_address
// out      output     out_valid / out_ready     phase, error_code, fuse_bit, fuse_checksum
// cfg      input      cfg_wr_en                 cfg_wr_data (fuse_total)
//
// a character or read item makes one row read of the fuse memory, then an update and
// write back; the next item is taken in the cycle its result is issued
// an F fill walks the memory one 8-fuse row a cycle, each row read and then written
// back with the fill value; no row is touched when the fuse total is 0
// after reset a clearing pass writes zero to every row (MAX_FUSES/8 rounded up, 1024 by
// default), with in_ready low
// the output register holds a result while out_ready is low; one further item is
// accepted and processed, its result waits until the register is free
module jedec_fuse_map_loader_unit
	import jfml_pkg::*;
#(
	parameter int MAX_FUSES = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [7:0]         char_in,
	input  logic [12:0]        read_address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         phase,
	output logic [2:0]         error_code,
	output logic               fuse_bit,
	output logic [15:0]        fuse_checksum,
	input  logic               cfg_wr_en,
	input  logic [TOTAL_W-1:0] cfg_wr_data
);

	localparam int ROWS = (MAX_FUSES + 7) / 8;
	localparam int RA_W = $clog2(ROWS);

	logic [TOTAL_W-1:0] fuse_total_q;
	logic               out_valid_q;
	res_t               res_q;
	res_t               res;
	logic               res_valid;
	logic               slot_free;

	logic               ram_rd_en;
	logic [RA_W-1:0]    ram_rd_addr;
	logic [7:0]         ram_rd_data;
	logic               ram_wr_en;
	logic [RA_W-1:0]    ram_wr_addr;
	logic [7:0]         ram_wr_data;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fuse_total_q <= TOTAL_RESET;
		end else if (cfg_wr_en) begin
			fuse_total_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	jfml_ctrl #(
		.MAX_FUSES(MAX_FUSES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fuse_total  (fuse_total_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.char_in     (char_in),
		.read_address(read_address),
		.slot_free   (slot_free),
		.res_valid   (res_valid),
		.res         (res),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data)
	);

	jfml_ram #(
		.DEPTH(ROWS)
	) u_ram (
		.clk    (clk),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data)
	);

	assign out_valid     = out_valid_q;
	assign phase         = res_q.phase;
	assign error_code    = res_q.error_code;
	assign fuse_bit      = res_q.fuse_bit;
	assign fuse_checksum = res_q.fuse_checksum;

endmodule

// ----- hdl/jfml_ram.sv -----
module jfml_ram #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/jfml_ctrl.sv -----
module jfml_ctrl
	import jfml_pkg::*;
#(
	parameter int MAX_FUSES = 8192
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [TOTAL_W-1:0]                     fuse_total,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   cmd,
	input  logic [7:0]                             char_in,
	input  logic [12:0]                            read_address,
	input  logic                                   slot_free,
	output logic                                   res_valid,
	output res_t                                   res,
	output logic                                   ram_rd_en,
	output logic [$clog2((MAX_FUSES+7)/8)-1:0]     ram_rd_addr,
	input  logic [7:0]                             ram_rd_data,
	output logic                                   ram_wr_en,
	output logic [$clog2((MAX_FUSES+7)/8)-1:0]     ram_wr_addr,
	output logic [7:0]                             ram_wr_data
);

	localparam int ROWS  = (MAX_FUSES + 7) / 8;
	localparam int RA_W  = $clog2(ROWS);
	localparam int RC_W  = $clog2(ROWS + 1);
	localparam int PTR_W = $clog2(MAX_FUSES + 1);
	localparam int CW    = (PTR_W > TOTAL_W) ? PTR_W : TOTAL_W;

	seq_t              state_q, state_n;
	pmode_t            mode_q, mode_n;
	logic [PTR_W-1:0]  ptr_q, ptr_n;
	logic              digit_q, digit_n;
	logic              dflt_q, dflt_n;
	err_t              err_q, err_n;
	logic [15:0]       csum_q, csum_n;
	logic              bit_q, bit_n;
	logic              fill_val_q, fill_val_n;
	logic [RC_W-1:0]   cnt_q, cnt_n;
	logic              fwr_s1, fwr_n;
	logic [RC_W-1:0]   frow_s1, frow_n;

	logic              cmd_q;
	char_t             char_q;
	logic [12:0]       addr_q;

	logic              accept;
	logic [CW-1:0]     tot_ext;
	logic [PTR_W-1:0]  eff_total;
	logic [RC_W-1:0]   rows_n;
	logic [RC_W-1:0]   full_rows;
	logic [7:0]        fill_mask;
	logic [7:0]        fill_byte;
	logic [7:0]        lbit_byte;
	logic [RA_W-1:0]   ptr_row;
	logic [RA_W-1:0]   acc_row;
	logic [PTR_W+3:0]  dec_sum;
	logic [PTR_W-1:0]  dec_ptr;
	logic              c_is_bit;
	logic              c_is_digit;
	logic              addr_in_range;
	phase_t            phase_w;

	assign accept    = in_valid & in_ready;
	assign tot_ext   = CW'(fuse_total);
	assign eff_total = (tot_ext < CW'(MAX_FUSES)) ? PTR_W'(tot_ext) : PTR_W'(MAX_FUSES);
	assign rows_n    = RC_W'(({1'b0, eff_total} + (PTR_W+1)'(7)) >> 3);
	assign full_rows = RC_W'(eff_total >> 3);

	assign fill_mask = (frow_s1 < full_rows) ? 8'hFF
		: 8'((9'd1 << eff_total[2:0]) - 9'd1);
	assign fill_byte = fill_val_q ? (ram_rd_data | fill_mask) : (ram_rd_data & ~fill_mask);

	assign ptr_row   = RA_W'(ptr_q >> 3);
	assign acc_row   = cmd ? RA_W'(read_address >> 3) : ptr_row;
	assign lbit_byte = (ram_rd_data & ~(8'd1 << ptr_q[2:0]))
		| (8'(char_q[0]) << ptr_q[2:0]);

	assign dec_sum = ({4'd0, ptr_q} << 3) + ({4'd0, ptr_q} << 1)
		+ (PTR_W+4)'(char_q[3:0]);
	assign dec_ptr = (dec_sum > (PTR_W+4)'(MAX_FUSES)) ? PTR_W'(MAX_FUSES) : PTR_W'(dec_sum);

	assign c_is_bit      = (char_q == CH_ZERO) || (char_q == CH_ONE);
	assign c_is_digit    = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
	assign addr_in_range = 32'(addr_q) < 32'(MAX_FUSES);

	always_comb begin
		unique case (mode_q)
			PM_WAIT_STX: phase_w = PH_WAIT_STX;
			PM_DONE:     phase_w = PH_DONE;
			PM_ERROR:    phase_w = PH_ERROR;
			default:     phase_w = PH_PARSE;
		endcase
	end

	assign res.phase         = phase_w;
	assign res.error_code    = err_q;
	assign res.fuse_bit      = bit_q;
	assign res.fuse_checksum = csum_q;

	always_comb begin
		state_n     = state_q;
		mode_n      = mode_q;
		ptr_n       = ptr_q;
		digit_n     = digit_q;
		dflt_n      = dflt_q;
		err_n       = err_q;
		csum_n      = csum_q;
		bit_n       = bit_q;
		fill_val_n  = fill_val_q;
		cnt_n       = cnt_q;
		fwr_n       = fwr_s1;
		frow_n      = frow_s1;
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = acc_row;
		ram_wr_en   = 1'b0;
		ram_wr_addr = ptr_row;
		ram_wr_data = lbit_byte;

		unique case (state_q)
			SQ_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = RA_W'(cnt_q);
				ram_wr_data = 8'd0;
				if (cnt_q == RC_W'(ROWS - 1)) begin
					state_n = SQ_IDLE;
				end else begin
					cnt_n = cnt_q + RC_W'(1);
				end
			end
			SQ_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ram_rd_en = 1'b1;
					state_n   = SQ_EXEC;
				end
			end
			SQ_EXEC: begin
				state_n = SQ_RESP;
				bit_n   = 1'b0;
				if (cmd_q) begin
					bit_n = addr_in_range ? ram_rd_data[addr_q[2:0]] : 1'b0;
				end else begin
					unique case (mode_q)
						PM_WAIT_STX: begin
							if (char_q == CH_STX) begin
								mode_n = PM_HEADER;
							end
						end
						PM_HEADER, PM_SKIP: begin
							if (char_q == CH_STAR) begin
								mode_n = PM_FIELD;
							end
						end
						PM_FIELD: begin
							priority if (is_space(char_q)) begin
								mode_n = PM_FIELD;
							end else if (char_q == CH_F) begin
								if (dflt_q) begin
									mode_n = PM_ERROR;
									err_n  = ERR_F_TWICE;
								end else begin
									dflt_n = 1'b1;
									mode_n = PM_FVAL;
								end
							end else if (char_q == CH_L) begin
								ptr_n   = '0;
								digit_n = 1'b0;
								mode_n  = PM_LNUM;
							end else if (char_q == CH_ETX) begin
								mode_n = PM_DONE;
							end else begin
								mode_n = PM_SKIP;
							end
						end
						PM_FVAL: begin
							if (c_is_bit) begin
								fill_val_n = char_q[0];
								cnt_n      = '0;
								fwr_n      = 1'b0;
								mode_n     = PM_SKIP;
								state_n    = SQ_FILL;
							end else begin
								mode_n = PM_ERROR;
								err_n  = ERR_F_VALUE;
							end
						end
						PM_LNUM: begin
							priority if (c_is_digit) begin
								digit_n = 1'b1;
								ptr_n   = dec_ptr;
							end else if (is_space(char_q)) begin
								priority if (!digit_q) begin
									mode_n = PM_ERROR;
									err_n  = ERR_FUSE_NUM;
								end else if (ptr_q >= eff_total) begin
									mode_n = PM_ERROR;
									err_n  = ERR_NUM_RANGE;
								end else begin
									mode_n = PM_LBITS;
								end
							end else begin
								mode_n = PM_ERROR;
								err_n  = ERR_FUSE_NUM;
							end
						end
						PM_LBITS: begin
							priority if (is_space(char_q)) begin
								mode_n = PM_LBITS;
							end else if (c_is_bit) begin
								if (ptr_q >= eff_total) begin
									mode_n = PM_ERROR;
									err_n  = ERR_PAST_END;
								end else begin
									ram_wr_en = 1'b1;
									csum_n    = csum_q + {8'd0, lbit_byte} - {8'd0, ram_rd_data};
									ptr_n     = ptr_q + PTR_W'(1);
								end
							end else if (char_q == CH_STAR) begin
								mode_n = PM_FIELD;
							end else begin
								mode_n = PM_ERROR;
								err_n  = ERR_BIT_CHAR;
							end
						end
						default: begin
							mode_n = mode_q;
						end
					endcase
				end
			end
			SQ_FILL: begin
				if (fwr_s1) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = RA_W'(frow_s1);
					ram_wr_data = fill_byte;
					csum_n      = csum_q + {8'd0, fill_byte} - {8'd0, ram_rd_data};
				end
				if (cnt_q < rows_n) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = RA_W'(cnt_q);
					cnt_n       = cnt_q + RC_W'(1);
					fwr_n       = 1'b1;
					frow_n      = cnt_q;
				end else begin
					fwr_n = 1'b0;
					if (!fwr_s1) begin
						state_n = SQ_RESP;
					end
				end
			end
			SQ_RESP: begin
				if (slot_free) begin
					res_valid = 1'b1;
					in_ready  = 1'b1;
					if (in_valid) begin
						ram_rd_en = 1'b1;
						state_n   = SQ_EXEC;
					end else begin
						state_n = SQ_IDLE;
					end
				end
			end
			default: begin
				state_n = SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= PM_WAIT_STX;
			ptr_q      <= '0;
			digit_q    <= 1'b0;
			dflt_q     <= 1'b0;
			err_q      <= ERR_NONE;
			csum_q     <= '0;
			bit_q      <= 1'b0;
			fill_val_q <= 1'b0;
			cnt_q      <= '0;
			fwr_s1     <= 1'b0;
			frow_s1    <= '0;
		end else begin
			mode_q     <= mode_n;
			ptr_q      <= ptr_n;
			digit_q    <= digit_n;
			dflt_q     <= dflt_n;
			err_q      <= err_n;
			csum_q     <= csum_n;
			bit_q      <= bit_n;
			fill_val_q <= fill_val_n;
			cnt_q      <= cnt_n;
			fwr_s1     <= fwr_n;
			frow_s1    <= frow_n;
		end
	end

	// item capture on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			char_q <= char_in;
			addr_q <= read_address;
		end
	end

	a_rw_row: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_rd_en && ram_wr_en && (ram_rd_addr == ram_wr_addr)))
		else $error("read and write of one row in the same cycle");

	a_res_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> slot_free)
		else $error("result issued with output register full");

	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_CLEAR) |-> !in_ready)
		else $error("input taken during clearing pass");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == PM_ERROR) |=> ((mode_q == PM_ERROR) && $stable(err_q)))
		else $error("error state left or code changed");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == PM_ERROR) |-> (err_q != ERR_NONE))
		else $error("error state without error code");

	a_fill_row: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == SQ_FILL) && ram_wr_en) |-> (frow_s1 < rows_n))
		else $error("fill wrote beyond the fuse count");

endmodule

// ----- tb/fuse_load_checker.sv -----
`timescale 1ns / 1ps
module fuse_load_checker
	import jfml_pkg::*;
#(
	parameter int FUSE_CAP = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               cmd,
	input  logic [7:0]         char_in,
	input  logic [12:0]        read_address,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         phase,
	input  logic [2:0]         error_code,
	input  logic               fuse_bit,
	input  logic [15:0]        fuse_checksum,
	input  logic               cfg_wr_en,
	input  logic [TOTAL_W-1:0] cfg_wr_data,
	output int                 mismatches,
	output int                 pending
);

	pmode_t              mode;
	logic [FUSE_CAP-1:0] fuse_image;
	int                  fuse_ptr;
	logic                digit_seen;
	logic                fill_done;
	logic [15:0]         checksum;
	err_t                err;
	logic [TOTAL_W-1:0]  total;
	res_t                expected_q[$];
	int                  n_in;
	int                  n_out;

	assign pending = n_in - n_out;

	function automatic logic is_gap(char_t c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic int usable_fuses();
		return (int'(total) < FUSE_CAP) ? int'(total) : FUSE_CAP;
	endfunction

	task automatic write_fuse(int idx, logic v);
		logic [15:0] w;
		w = 16'd1 << (idx % 8);
		if (fuse_image[idx] != v) begin
			if (v)
				checksum = checksum + w;
			else
				checksum = checksum - w;
			fuse_image[idx] = v;
		end
	endtask

	task automatic trip(err_t code);
		err = code;
		mode = PM_ERROR;
	endtask

	task automatic parse(char_t c);
		int n;
		int i;
		case (mode)
			PM_WAIT_STX: if (c == CH_STX) mode = PM_HEADER;
			PM_HEADER, PM_SKIP: if (c == CH_STAR) mode = PM_FIELD;
			PM_FIELD: begin
				if (is_gap(c)) begin
				end else if (c == CH_F) begin
					if (fill_done) begin
						trip(ERR_F_TWICE);
					end else begin
						fill_done = 1'b1;
						mode = PM_FVAL;
					end
				end else if (c == CH_L) begin
					fuse_ptr = 0;
					digit_seen = 1'b0;
					mode = PM_LNUM;
				end else if (c == CH_ETX) begin
					mode = PM_DONE;
				end else begin
					mode = PM_SKIP;
				end
			end
			PM_FVAL: begin
				if (c == CH_ZERO || c == CH_ONE) begin
					n = usable_fuses();
					for (i = 0; i < n; i++)
						write_fuse(i, c[0]);
					mode = PM_SKIP;
				end else begin
					trip(ERR_F_VALUE);
				end
			end
			PM_LNUM: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					digit_seen = 1'b1;
					fuse_ptr = fuse_ptr * 10 + int'(c - CH_ZERO);
					if (fuse_ptr > FUSE_CAP)
						fuse_ptr = FUSE_CAP;
				end else if (is_gap(c)) begin
					if (!digit_seen)
						trip(ERR_FUSE_NUM);
					else if (fuse_ptr >= usable_fuses())
						trip(ERR_NUM_RANGE);
					else
						mode = PM_LBITS;
				end else begin
					trip(ERR_FUSE_NUM);
				end
			end
			PM_LBITS: begin
				if (is_gap(c)) begin
				end else if (c == CH_ZERO || c == CH_ONE) begin
					if (fuse_ptr >= usable_fuses()) begin
						trip(ERR_PAST_END);
					end else begin
						write_fuse(fuse_ptr, c[0]);
						fuse_ptr++;
					end
				end else if (c == CH_STAR) begin
					mode = PM_FIELD;
				end else begin
					trip(ERR_BIT_CHAR);
				end
			end
			default: ;
		endcase
	endtask

	task automatic compare(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			mode = PM_WAIT_STX;
			fuse_image = '0;
			fuse_ptr = 0;
			digit_seen = 1'b0;
			fill_done = 1'b0;
			checksum = '0;
			err = ERR_NONE;
			total = TOTAL_RESET;
			expected_q.delete();
			mismatches = 0;
			n_in <= 0;
			n_out <= 0;
		end else begin
			if (cfg_wr_en)
				total = cfg_wr_data;
			if (in_valid && in_ready) begin
				want.fuse_bit = 1'b0;
				if (cmd)
					want.fuse_bit = fuse_image[read_address];
				else
					parse(char_in);
				case (mode)
					PM_WAIT_STX: want.phase = PH_WAIT_STX;
					PM_DONE: want.phase = PH_DONE;
					PM_ERROR: want.phase = PH_ERROR;
					default: want.phase = PH_PARSE;
				endcase
				want.error_code = err;
				want.fuse_checksum = checksum;
				expected_q.push_back(want);
				n_in <= n_in + 1;
			end
			if (out_valid && out_ready) begin
				n_out <= n_out + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: result transfer expected none actual phase %0d error %0d bit %0d sum %0d",
						$time, phase, error_code, fuse_bit, fuse_checksum);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					compare("phase", 16'(want.phase), 16'(phase));
					compare("error_code", 16'(want.error_code), 16'(error_code));
					compare("fuse_bit", 16'(want.fuse_bit), 16'(fuse_bit));
					compare("fuse_checksum", want.fuse_checksum, fuse_checksum);
				end
			end
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import jfml_pkg::*;

	localparam int ITEMS       = 1850;
	localparam int FUSE_CAP    = 8192;
	localparam int STALL_LIMIT = 6000;
	localparam int SETTLE      = 8;

	typedef enum int {
		END_ETX,
		END_F_TWICE,
		END_F_VALUE,
		END_EMPTY_NUM,
		END_BIG_NUM,
		END_BAD_BIT,
		END_PAST_END
	} finish_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               cmd = 1'b0;
	logic [7:0]         char_in = '0;
	logic [12:0]        read_address = '0;
	logic               out_valid;
	logic               out_ready = 1'b1;
	logic [1:0]         phase;
	logic [2:0]         error_code;
	logic               fuse_bit;
	logic [15:0]        fuse_checksum;
	logic               cfg_wr_en = 1'b0;
	logic [TOTAL_W-1:0] cfg_wr_data = TOTAL_RESET;
	int                 mismatches;
	int                 pending;
	int                 sent = 0;
	int                 quiet = 0;
	int                 hold = 0;
	int                 live_total = FUSE_CAP;
	logic               calm = 1'b0;
	logic               fill_used = 1'b0;

	always #6 clk = ~clk;

	jedec_fuse_map_loader_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.char_in(char_in),
		.read_address(read_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.phase(phase),
		.error_code(error_code),
		.fuse_bit(fuse_bit),
		.fuse_checksum(fuse_checksum),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	fuse_load_checker #(.FUSE_CAP(FUSE_CAP)) u_load_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.char_in(char_in),
		.read_address(read_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.phase(phase),
		.error_code(error_code),
		.fuse_bit(fuse_bit),
		.fuse_checksum(fuse_checksum),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	// result side back-pressure
	always @(posedge clk) begin
		if (hold != 0)
			hold = hold - 1;
		else if (!calm && $urandom_range(0, 11) == 0)
			hold = $urandom_range(1, 7);
		out_ready <= (hold == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_item(logic c, char_t ch, logic [12:0] addr);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		char_in <= ch;
		read_address <= addr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		calm = (sent >= ITEMS - 200);
	endtask

	// file character, now and then preceded by a read-back
	task automatic send_char(char_t ch);
		if ($urandom_range(0, 5) == 0)
			send_item(1'b1, 8'($urandom),
				$urandom_range(0, 1) ? 13'($urandom_range(0, 255)) : 13'($urandom));
		send_item(1'b0, ch, 13'($urandom));
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic char_t blank_char();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic int usable();
		return (live_total < FUSE_CAP) ? live_total : FUSE_CAP;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_total(int v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= TOTAL_W'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		live_total = v;
	endtask

	task automatic send_lfield(int num, int nbits, logic close);
		string digits;
		digits = $sformatf("%0d", num);
		if ($urandom_range(0, 7) == 0)
			digits = {"0", digits};
		send_text({"L", digits});
		send_char(blank_char());
		repeat (nbits) begin
			if ($urandom_range(0, 4) == 0)
				send_char(blank_char());
			send_char(CH_ZERO + char_t'($urandom_range(0, 1)));
		end
		if (close) begin
			if ($urandom_range(0, 3) == 0)
				send_char(blank_char());
			send_char(CH_STAR);
		end
	endtask

	// field body up to and including the closing star
	task automatic send_tail_to_star(int most);
		char_t c;
		repeat ($urandom_range(0, most)) begin
			do c = 8'($urandom); while (c == CH_STAR);
			send_char(c);
		end
		send_char(CH_STAR);
	endtask

	task automatic send_fill();
		send_text("F");
		send_char(CH_ZERO + char_t'($urandom_range(0, 1)));
		send_tail_to_star(4);
		fill_used = 1'b1;
	endtask

	task automatic send_random_field(logic fill_ok);
		string letters;
		int eff;
		int num;
		int room;
		letters = "NVfl";
		eff = usable();
		repeat ($urandom_range(0, 2)) send_char(blank_char());
		if (fill_ok && !fill_used && $urandom_range(0, 9) == 0) begin
			send_fill();
		end else if (eff > 0 && $urandom_range(0, 9) < 7) begin
			if ($urandom_range(0, 1))
				num = $urandom_range(0, (eff > 256) ? 255 : eff - 1);
			else
				num = $urandom_range(0, eff - 1);
			room = eff - num;
			send_lfield(num, $urandom_range(0, (room > 24) ? 24 : room), 1'b1);
		end else begin
			if ($urandom_range(0, 1))
				send_char(letters[$urandom_range(0, 3)]);
			else
				send_char(8'($urandom_range(8'h4D, 8'hFF)));
			send_tail_to_star(12);
		end
	endtask

	initial begin
		finish_t ending;
		int totals[6];
		int eff;
		int num;
		char_t c;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		set_total(int'(TOTAL_RESET));

		// extremes, noise before and inside the header, simple fields
		send_item(1'b1, 8'hFF, 13'd0);
		send_item(1'b1, 8'h00, 13'h1FFF);
		send_char(8'h00);
		send_char(8'hFF);
		send_char(CH_ETX);
		send_char(CH_STX);
		send_char(8'hFF);
		send_char(CH_STX);
		send_char(CH_STAR);
		send_text("N x*");
		send_text("L0 10*");
		send_text("L8191\t1\r*");
		send_item(1'b1, 8'h55, 13'h1FFF);
		send_item(1'b1, 8'hAA, 13'd1);

		ending = finish_t'($urandom_range(0, 6));
		totals = '{$urandom_range(1, FUSE_CAP), 1, 0, 16383, $urandom_range(16, 300),
			$urandom_range(1, FUSE_CAP)};
		for (int s = 0; s < 6; s++) begin
			set_total(totals[s]);
			if (s == 4 && !fill_used && ending != END_F_VALUE)
				send_fill();
			while (sent < (s + 1) * (ITEMS - 80) / 6)
				send_random_field(ending != END_F_VALUE);
		end

		eff = usable();
		repeat ($urandom_range(0, 2)) send_char(blank_char());
		case (ending)
			END_ETX: send_char(CH_ETX);
			END_F_TWICE: begin
				if (!fill_used)
					send_fill();
				send_text("F");
			end
			END_F_VALUE: begin
				send_text("F");
				c = $urandom_range(0, 1) ? 8'($urandom_range(8'h32, 8'hFF)) : blank_char();
				send_char(c);
			end
			END_EMPTY_NUM: begin
				send_text("L");
				c = $urandom_range(0, 1) ? 8'($urandom_range(8'h3A, 8'hFF)) : blank_char();
				send_char(c);
			end
			END_BIG_NUM: begin
				send_text({"L", $sformatf("%0d", $urandom_range(eff, 99999))});
				send_char(blank_char());
			end
			END_BAD_BIT: begin
				num = $urandom_range(0, eff - 1);
				send_lfield(num, $urandom_range(0, (eff - num > 8) ? 8 : eff - num), 1'b0);
				c = $urandom_range(0, 1) ? 8'($urandom_range(8'h32, 8'hFF)) : CH_ETX;
				send_char(c);
			end
			default: begin
				num = eff - $urandom_range(1, (eff < 8) ? eff : 8);
				send_lfield(num, eff - num + $urandom_range(1, 3), 1'b0);
			end
		endcase

		// parser has stopped: characters are ignored, reads still answer
		repeat (60) send_item($urandom_range(0, 1), 8'($urandom), 13'($urandom));

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
